// ===== rtl/pht_pkg.sv =====
package pht_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 12;
	localparam int TIME_IN_W = 48;
	localparam int MS_W = 32;
	localparam int RPM_W = 26;
	localparam int PPR_W = 8;
	localparam int PROD_W = RPM_W + PPR_W;
	localparam int TIME_BITS_DEF = 48;

	// Register port
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// Arithmetic constants
	localparam logic [RPM_W-1:0] RPM_NUMERATOR = 26'd60000000;
	localparam logic [9:0] US_PER_MS = 10'd1000;

	// Microseconds to milliseconds: time * ceil(2^53 / 1000) >> 53 is exact for any
	// time below 2^48. The product is accumulated one 16-bit time digit per cycle.
	localparam int MS_DIG_W = 16;
	localparam int MS_RECIP_W = 44;
	localparam logic [MS_RECIP_W-1:0] MS_RECIP = 44'd9007199254741;
	localparam int MS_SHIFT = 53;
	localparam int MS_ACC_W = 96;

	// Register reset values
	localparam logic [SAMPLE_W-1:0] TRIGGER_RST = 12'd1000;
	localparam logic [SAMPLE_W-1:0] REARM_RST = 12'd1200;
	localparam logic [PPR_W-1:0] PPR_RST = 8'd1;

	typedef enum logic [1:0] {
		REG_TRIGGER = 2'd0,
		REG_REARM   = 2'd1,
		REG_PPR     = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_TDIV,
		ST_RDIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic pulse_upd;
		logic rearm;
		logic start_tdiv;
		logic start_rdiv;
		logic latch_ms;
		logic latch_rpm;
		logic clear_rpm;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic pulse;
		logic rearm_hit;
		logic ms_busy;
		logic div_busy;
		logic rpm_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/pht_div.sv =====
module pht_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 34,
	parameter int CNT_W = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [CNT_W-1:0] steps,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] sub;
	logic             ge;

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign sub = {1'b0, trial} - {2'b00, den_q};
	assign ge = !sub[DEN_W+1];
	assign busy = (cnt_q != '0);
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

endmodule

// ===== rtl/pht_datapath.sv =====
module pht_datapath #(
	parameter int TIME_BITS = pht_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pht_pkg::cmd_t                 cmd,
	output pht_pkg::sts_t                 sts,
	input  logic [pht_pkg::SAMPLE_W-1:0]  trigger_threshold,
	input  logic [pht_pkg::SAMPLE_W-1:0]  rearm_threshold,
	input  logic [pht_pkg::PPR_W-1:0]     ppr_cfg,
	input  logic [pht_pkg::SAMPLE_W-1:0]  in_sample,
	input  logic [pht_pkg::TIME_IN_W-1:0] in_time,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [pht_pkg::MS_W-1:0]      out_ms,
	output logic [pht_pkg::RPM_W-1:0]     out_rpm,
	output logic                          out_first
);
	import pht_pkg::*;

	// Only the low TIME_BITS bits of the time are used; the port carries 48.
	localparam int TW = (TIME_BITS < TIME_IN_W) ? TIME_BITS : TIME_IN_W;
	localparam int DIGITS = (TW + MS_DIG_W - 1) / MS_DIG_W;
	localparam int TPAD_W = DIGITS * MS_DIG_W;
	localparam int MS_CNT_W = $clog2(DIGITS + 1);
	localparam int PART_W = MS_DIG_W + MS_RECIP_W;
	localparam int DIV_CNT_W = $clog2(RPM_W + 1);

	logic [SAMPLE_W-1:0] sample_q;
	logic [TW-1:0]       time_q;
	logic                disarmed_q;
	logic                have_prev_q;
	logic [TW-1:0]       prev_q;
	logic                first_q;
	logic                after_q;
	logic [TW-1:0]       delta_q;
	logic [PROD_W-1:0]   prod_q;
	logic [MS_W-1:0]     ms_q;
	logic [RPM_W-1:0]    rpm_q;
	logic                out_valid_q;
	logic [MS_W-1:0]     out_ms_q;
	logic [RPM_W-1:0]    out_rpm_q;
	logic                out_first_q;
	logic [PPR_W-1:0]    ppr_eff;
	logic [TPAD_W-1:0]   tsh_q;
	logic [MS_ACC_W-1:0] acc_q;
	logic [MS_CNT_W-1:0] ms_cnt_q;
	logic                ms_busy;
	logic [PART_W-1:0]   part;
	logic                div_busy;
	logic [RPM_W-1:0]    div_quo;

	assign ppr_eff = (ppr_cfg == '0) ? PPR_W'(1) : ppr_cfg;

	assign sts.pulse = (sample_q < trigger_threshold) && !disarmed_q;
	assign sts.rearm_hit = (sample_q > rearm_threshold) && disarmed_q;
	assign sts.ms_busy = ms_busy;
	assign sts.div_busy = div_busy;
	assign sts.rpm_zero = first_q || !after_q ||
		(delta_q > {{(TW-RPM_W){1'b0}}, RPM_NUMERATOR});
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disarmed_q <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q <= '0;
		end else if (cmd.pulse_upd) begin
			disarmed_q <= 1'b1;
			have_prev_q <= 1'b1;
			prev_q <= time_q;
		end else if (cmd.rearm) begin
			disarmed_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= in_sample;
			time_q <= in_time[TW-1:0];
		end
		if (cmd.pulse_upd) begin
			first_q <= !have_prev_q;
			after_q <= (time_q > prev_q);
			delta_q <= time_q - prev_q;
		end
		prod_q <= PROD_W'(delta_q[RPM_W-1:0]) * PROD_W'(ppr_eff);
		if (cmd.latch_ms) begin
			ms_q <= acc_q[MS_SHIFT +: MS_W];
		end
		if (cmd.latch_rpm) begin
			rpm_q <= div_quo;
		end else if (cmd.clear_rpm) begin
			rpm_q <= '0;
		end
	end

	// Milliseconds by reciprocal multiplication. The time is consumed one digit
	// per cycle, top digit first, so the accumulator shifts and adds one partial
	// product each cycle.
	assign ms_busy = (ms_cnt_q != '0);
	assign part = PART_W'(tsh_q[TPAD_W-1 -: MS_DIG_W]) * PART_W'(MS_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_cnt_q <= '0;
		end else if (cmd.start_tdiv) begin
			ms_cnt_q <= MS_CNT_W'(DIGITS);
		end else if (ms_busy) begin
			ms_cnt_q <= ms_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_tdiv) begin
			tsh_q <= TPAD_W'(time_q);
			acc_q <= '0;
		end else if (ms_busy) begin
			tsh_q <= tsh_q << MS_DIG_W;
			acc_q <= {acc_q[MS_ACC_W-MS_DIG_W-1:0], {MS_DIG_W{1'b0}}} + MS_ACC_W'(part);
		end
	end

	// Speed divider: 60000000 / (period * ppr), one quotient bit per cycle.
	pht_div #(
		.NUM_W(RPM_W),
		.DEN_W(PROD_W),
		.CNT_W(DIV_CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start_rdiv),
		.num   (RPM_NUMERATOR),
		.den   (prod_q),
		.steps (DIV_CNT_W'(RPM_W)),
		.busy  (div_busy),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ms_q <= ms_q;
			out_rpm_q <= rpm_q;
			out_first_q <= first_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ms = out_ms_q;
	assign out_rpm = out_rpm_q;
	assign out_first = out_first_q;

endmodule

// ===== rtl/pht_ctrl.sv =====
module pht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pht_pkg::sts_t sts,
	output pht_pkg::cmd_t cmd
);
	import pht_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.pulse) begin
					cmd.pulse_upd = 1'b1;
					cmd.start_tdiv = 1'b1;
					state_d = ST_TDIV;
				end else begin
					cmd.rearm = sts.rearm_hit;
					state_d = ST_IDLE;
				end
			end
			ST_TDIV: begin
				if (!sts.ms_busy) begin
					cmd.latch_ms = 1'b1;
					if (sts.rpm_zero) begin
						cmd.clear_rpm = 1'b1;
						state_d = ST_EMIT;
					end else begin
						cmd.start_rdiv = 1'b1;
						state_d = ST_RDIV;
					end
				end
			end
			ST_RDIV: begin
				if (!sts.div_busy) begin
					cmd.latch_rpm = 1'b1;
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/pulse_hysteresis_tachometer.sv =====
// A sample that is not a pulse is evaluated, and then the input is ready for the next transfer.
// A pulse reaches m_tvalid after the digit-wise millisecond multiplication and the speed
// division; the division is skipped when the speed is 0.
// The result register lets the next sample in while a result waits. Reset (arst_n low,
// asynchronous) arms the detector, forgets the previous pulse and loads the register
// defaults 1000, 1200 and 1.
module pulse_hysteresis_tachometer #(
	parameter int TIME_BITS = pht_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Register port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pht_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [pht_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [pht_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	// Sample stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [63:0]                     s_tdata,  // sample_value[11:0], time_us[59:12]
	// Pulse result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [63:0]                     m_tdata,  // pulse_time_ms[31:0], speed_rpm[57:32]
	output logic [0:0]                      m_tuser   // first_pulse[0]
);
	import pht_pkg::*;

	logic [SAMPLE_W-1:0] trigger_q;
	logic [SAMPLE_W-1:0] rearm_q;
	logic [PPR_W-1:0]    ppr_q;
	logic                cfg_wr;
	reg_idx_t            reg_sel;
	cmd_t                cmd;
	sts_t                sts;
	logic [MS_W-1:0]     out_ms;
	logic [RPM_W-1:0]    out_rpm;
	logic                out_first;

	// The registers sit at byte addresses 0, 4 and 8. A write completes in the
	// access phase; the port never stalls. Writing the unused word address is ignored.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= TRIGGER_RST;
			rearm_q <= REARM_RST;
			ppr_q <= PPR_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_TRIGGER: trigger_q <= pwdata[SAMPLE_W-1:0];
				REG_REARM:   rearm_q <= pwdata[SAMPLE_W-1:0];
				REG_PPR:     ppr_q <= pwdata[PPR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_TRIGGER: prdata = CFG_DATA_W'(trigger_q);
			REG_REARM:   prdata = CFG_DATA_W'(rearm_q);
			REG_PPR:     prdata = CFG_DATA_W'(ppr_q);
			default:     prdata = '0;
		endcase
	end

	// The controller sequences each sample: evaluate the thresholds, then on a
	// pulse convert the time to milliseconds, run the speed division unless the speed is zero, and
	// finally hand the result to the output register.
	pht_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	pht_datapath #(
		.TIME_BITS(TIME_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.trigger_threshold(trigger_q),
		.rearm_threshold  (rearm_q),
		.ppr_cfg          (ppr_q),
		.in_sample        (s_tdata[11:0]),
		.in_time          (s_tdata[59:12]),
		.out_ready        (m_tready),
		.out_valid        (m_tvalid),
		.out_ms           (out_ms),
		.out_rpm          (out_rpm),
		.out_first        (out_first)
	);

	// Result transfer: data bits above the speed field are zero.
	assign m_tdata = {6'b000000, out_rpm, out_ms};
	assign m_tuser = out_first;

endmodule

// ===== bench/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pht_pkg::*;

	// Write address 12 lies past the last register, so the block must drop the write.
	localparam int REG_SPARE = 3;
	// Tail after the last expected pulse, comfortably longer than a pulse takes in the block.
	localparam int TAIL_CYCLES = 100;

	// One expected pulse result, laid out as the three output fields.
	typedef struct packed {
		logic [MS_W-1:0]  time_ms;
		logic [RPM_W-1:0] speed;
		logic             first_flag;
	} pulse_rec_t;

	// The scoreboard tracks the block's own state and configuration. Each accepted
	// sample either becomes an expected pulse or only moves the arming state.
	// The instance keeps the default TIME_BITS, which equals the time field width,
	// so no masking of the time is needed.
	class tach_checker;
		logic [SAMPLE_W-1:0]  trigger_level;
		logic [SAMPLE_W-1:0]  rearm_level;
		logic [PPR_W-1:0]     pulses_per_rev;
		bit                   disarmed;
		bit                   seen_pulse;
		logic [TIME_IN_W-1:0] prev_pulse_us;
		pulse_rec_t           expected_pulses[$];
		int                   errors;

		function new();
			trigger_level = TRIGGER_RST;
			rearm_level = REARM_RST;
			pulses_per_rev = PPR_RST;
			disarmed = 1'b0;
			seen_pulse = 1'b0;
			prev_pulse_us = '0;
			errors = 0;
		endfunction

		function void load_reg(int idx, logic [31:0] word);
			case (idx)
				REG_TRIGGER: trigger_level = word[SAMPLE_W-1:0];
				REG_REARM:   rearm_level = word[SAMPLE_W-1:0];
				REG_PPR:     pulses_per_rev = word[PPR_W-1:0];
				default:     ;
			endcase
		endfunction

		function void predict_pulse(logic [SAMPLE_W-1:0] level, logic [TIME_IN_W-1:0] t_us);
			pulse_rec_t  rec;
			logic [63:0] period;
			logic [63:0] ppr;
			logic [63:0] rpm;
			logic [63:0] ms;
			if (level < trigger_level && !disarmed) begin
				ppr = (pulses_per_rev == '0) ? 64'd1 : 64'(pulses_per_rev);
				rpm = '0;
				if (seen_pulse && t_us > prev_pulse_us) begin
					period = 64'(t_us - prev_pulse_us);
					// Periods beyond one minute would give less than 1 rpm anyway.
					if (period <= 64'(RPM_NUMERATOR))
						rpm = 64'(RPM_NUMERATOR) / (period * ppr);
				end
				ms = 64'(t_us) / 64'(US_PER_MS);
				rec.time_ms = ms[MS_W-1:0];
				rec.speed = rpm[RPM_W-1:0];
				rec.first_flag = !seen_pulse;
				expected_pulses.push_back(rec);
				disarmed = 1'b1;
				seen_pulse = 1'b1;
				prev_pulse_us = t_us;
			end else if (level > rearm_level && disarmed) begin
				disarmed = 1'b0;
			end
		endfunction

		function int pending();
			return expected_pulses.size();
		endfunction

		function void report(string what, longint expv, longint actv);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expv, actv);
		endfunction

		function void check_pulse(logic [MS_W-1:0] ms, logic [RPM_W-1:0] rpm, logic first_flag);
			pulse_rec_t exp_rec;
			if (expected_pulses.size() == 0) begin
				errors++;
				$display("%0t: pulse result with none expected, ms %0d rpm %0d first %0b",
					$time, $signed(ms), rpm, first_flag);
				return;
			end
			exp_rec = expected_pulses.pop_front();
			if (ms !== exp_rec.time_ms)
				report("pulse_time_ms", longint'($signed(exp_rec.time_ms)), longint'($signed(ms)));
			if (rpm !== exp_rec.speed)
				report("speed_rpm", longint'(exp_rec.speed), longint'(rpm));
			if (first_flag !== exp_rec.first_flag)
				report("first_pulse", longint'(exp_rec.first_flag), longint'(first_flag));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [63:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [63:0]           m_tdata;
	logic [0:0]            m_tuser;

	tach_checker          tach;
	logic [TIME_IN_W-1:0] now_us;       // time base of the pulse samples
	int unsigned          cfg_trig;     // thresholds as last written, for shaping stimulus
	int unsigned          cfg_rearm;
	bit                   tx_idle_on;   // sender inserts random gaps
	bit                   rx_idle_on;   // receiver inserts random stalls
	int                   rx_hold_req;  // request for one long receiver hold-off

	pulse_hysteresis_tachometer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // sample_value[11:0], time_us[59:12]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // pulse_time_ms[31:0], speed_rpm[57:32]
		.m_tuser  (m_tuser)    // first_pulse[0]
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs. The slowest correct run takes under 2 ms.
	initial begin
		#(16_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	// Result side. Every cycle it checks a completed transfer at the rising edge and
	// then decides at the falling edge whether to offer tready. After each transfer
	// it draws a random stall if receiver idling is on; a hold-off request replaces
	// that stall with a long stretch so the block backs up and closes its input.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				tach.check_pulse(m_tdata[31:0], m_tdata[57:32], m_tuser[0]);
				stall_left = rx_idle_on ? $urandom_range(0, 4) : 0;
			end
			if (rx_hold_req > 0) begin
				stall_left = rx_hold_req;
				rx_hold_req = 0;
			end
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Offers one sample after a random gap and returns at the edge of its transfer.
	// If no gap is drawn, tvalid stays high straight into the next sample.
	task automatic send_sample(input logic [SAMPLE_W-1:0] level,
			input logic [TIME_IN_W-1:0] t_us);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {4'b0, t_us, level};
		do @(posedge clk); while (!s_tready);
		tach.predict_pulse(level, t_us);
	endtask

	// Register write: setup cycle, then access cycle. The upper bits of the word are
	// random, since only the register's own width should be kept.
	task automatic apb_write(input int idx, input int unsigned field);
		logic [31:0] word;
		word = $urandom();
		if (idx == REG_PPR)
			word[PPR_W-1:0] = field[PPR_W-1:0];
		else
			word[SAMPLE_W-1:0] = field[SAMPLE_W-1:0];
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = CFG_ADDR_W'(idx * 4);
		pwdata = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		tach.load_reg(idx, word);
		if (idx == REG_TRIGGER)
			cfg_trig = 32'(field[SAMPLE_W-1:0]);
		else if (idx == REG_REARM)
			cfg_rearm = 32'(field[SAMPLE_W-1:0]);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Stops offering samples and waits for every outstanding pulse. A sample that
	// gives no result may still be in flight, so a tail of cycles follows.
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (tach.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Level that fires a pulse while armed; with a zero trigger nothing can.
	function automatic logic [SAMPLE_W-1:0] pulse_level();
		if (cfg_trig == 0)
			return SAMPLE_W'($urandom_range(0, 4095));
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return SAMPLE_W'(cfg_trig - 1);
			default: return SAMPLE_W'($urandom_range(0, cfg_trig - 1));
		endcase
	endfunction

	// Level that rearms the detector; a threshold of 4095 can never be exceeded.
	function automatic logic [SAMPLE_W-1:0] rearm_level();
		if (cfg_rearm == 4095)
			return SAMPLE_W'($urandom_range(0, 4095));
		case ($urandom_range(0, 3))
			0:       return SAMPLE_W'(4095);
			1:       return SAMPLE_W'(cfg_rearm + 1);
			default: return SAMPLE_W'($urandom_range(cfg_rearm + 1, 4095));
		endcase
	endfunction

	// Level inside the hysteresis band, both thresholds included.
	function automatic logic [SAMPLE_W-1:0] band_level();
		if (cfg_trig <= cfg_rearm)
			return SAMPLE_W'($urandom_range(cfg_trig, cfg_rearm));
		return SAMPLE_W'($urandom_range(0, 4095));
	endfunction

	// Moves the pulse time base. The step sets the period seen by the next pulse,
	// so it covers equal and backward times, the one-minute boundary, short and
	// long periods, and random jumps across the whole 48-bit range.
	task automatic advance_time();
		case ($urandom_range(0, 15))
			0:             ;
			1:             now_us = now_us - $urandom_range(1, 100000);
			2:             now_us = TIME_IN_W'({$urandom(), $urandom()});
			3:             now_us = now_us + 48'd60000000;
			4:             now_us = now_us + 48'd60000001 + $urandom_range(0, 1000);
			5:             now_us = now_us + $urandom_range(59999000, 60000000);
			6, 7:          now_us = now_us + $urandom_range(1, 300);
			8, 9, 10, 11:  now_us = now_us + $urandom_range(300, 100000);
			default:       now_us = now_us + $urandom_range(100000, 60000000);
		endcase
	endtask

	// Mostly complete pulse cycles: a pulse sample, some in-band samples, then a
	// rearm sample. Only the pulse sample moves the time base, so the period is the drawn
	// step unless a noise sample pulsed in between. Noise uses random levels and times.
	task automatic random_items(input int count);
		int sent;
		int extra;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 7) begin
				advance_time();
				send_sample(pulse_level(), now_us);
				extra = $urandom_range(0, 2);
				repeat (extra) send_sample(band_level(), now_us + $urandom_range(0, 999));
				send_sample(rearm_level(), now_us + $urandom_range(0, 999));
				sent += extra + 2;
			end else begin
				if ($urandom_range(0, 1))
					send_sample(SAMPLE_W'($urandom_range(0, 4095)),
						TIME_IN_W'({$urandom(), $urandom()}));
				else
					send_sample(SAMPLE_W'($urandom_range(0, 4095)),
						now_us + $urandom_range(0, 999));
				sent++;
			end
		end
	endtask

	task automatic run_phase(input int unsigned trig, input int unsigned rearm,
			input int unsigned ppr, input int count);
		settle();
		apb_write(REG_TRIGGER, trig);
		apb_write(REG_REARM, rearm);
		apb_write(REG_PPR, ppr);
		random_items(count);
	endtask

	initial begin : stimulus
		int unsigned trig_pick;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold_req = 0;
		now_us = '0;
		cfg_trig = 32'(TRIGGER_RST);
		cfg_rearm = 32'(REARM_RST);
		tach = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed samples at the reset settings (trigger 1000, rearm 1200, one pulse
		// per rotation).
		send_sample(12'd1500, 48'd5);                // armed, but above trigger
		send_sample(12'd0, 48'd1000);                // first pulse: speed unknown
		send_sample(12'd999, 48'd2000);              // disarmed, no second pulse
		send_sample(12'd1200, 48'd2100);             // equal to rearm: still disarmed
		send_sample(12'd1201, 48'd2200);             // rearms
		send_sample(12'd999, 48'd1001);              // period of 1 us: top speed
		send_sample(12'd4095, 48'd3000);
		send_sample(12'd1000, 48'd3100);             // equal to trigger: no pulse
		send_sample(12'd500, 48'd1001);              // same time as last pulse
		send_sample(12'd4095, 48'd0);
		send_sample(12'd0, 48'd1000);                // time went backward
		send_sample(12'd4095, 48'd5);
		send_sample(12'd0, 48'd60001000);            // period of exactly one minute
		send_sample(12'd4095, 48'd1);
		send_sample(12'd0, 48'd121001001);           // period over one minute
		send_sample(12'd4095, 48'd2);
		send_sample(12'd0, 48'hFFFF_FFFF_FFFF);      // largest time
		send_sample(12'd4095, 48'hFFFF_FFFF_FFFF);
		send_sample(12'd0, 48'd0);                   // wraps back to zero

		// A write past the register list must leave everything as it was.
		settle();
		apb_write(REG_SPARE, $urandom_range(0, 4095));

		// Inverted hysteresis: a level of 2000 both fires and rearms, so pulses and
		// rearms alternate, and the pulse sample itself never rearms.
		apb_write(REG_TRIGGER, 3000);
		apb_write(REG_REARM, 500);
		send_sample(12'd2000, 48'd100);
		send_sample(12'd2000, 48'd200);
		send_sample(12'd2000, 48'd300);
		send_sample(12'd2000, 48'd300);

		// Random phases under several settings. A zero pulses-per-rotation counts
		// as one; a zero trigger never fires; a rearm of 4095 never rearms.
		run_phase(1000, 1200, 0, 200);
		repeat (3) begin
			trig_pick = $urandom_range(1, 4094);
			run_phase(trig_pick, $urandom_range(trig_pick, 4095), $urandom_range(1, 255), 280);
		end
		run_phase(4095, 0, 255, 150);
		run_phase(0, 4095, 1, 30);
		run_phase(4095, 4095, $urandom_range(1, 255), 30);
		run_phase(3000, 500, $urandom_range(1, 255), 150);

		// Back pressure: with the result side held off for a long stretch and the
		// sender never pausing, the result register fills and the input stalls.
		settle();
		tx_idle_on = 1'b0;
		rx_hold_req = 600;
		random_items(80);
		tx_idle_on = 1'b1;

		// A stretch with no idling on either side.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		trig_pick = $urandom_range(100, 3000);
		run_phase(trig_pick, trig_pick + $urandom_range(0, 1000), $urandom_range(1, 255), 200);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		trig_pick = $urandom_range(1, 4094);
		run_phase(trig_pick, $urandom_range(trig_pick, 4095), $urandom_range(1, 255), 100);

		settle();
		if (tach.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
